>>> hw/rtl/butterworth_biquad_lowpass_unit_defines.svh
// ----------------------------------------------------------------------------
// Biquad low-pass assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BUTTERWORTH_BIQUAD_LOWPASS_UNIT_DEFINES_SVH
`define BUTTERWORTH_BIQUAD_LOWPASS_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define BBL_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bbl assertion failed");
`define BBL_ASSERT_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("bbl forbidden condition seen");
`else
`define BBL_ASSERT(label, prop)
`define BBL_ASSERT_NEVER(label, expr)
`endif

`endif

>>> hw/rtl/bbl_pkg.sv
// ----------------------------------------------------------------------------
// Biquad low-pass package
// Shared types, register indexes and fixed-point widths.
// ----------------------------------------------------------------------------
package bbl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COEF_W = 18;
    localparam int PGAIN_W = 32;
    localparam int STATE_W = 48;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_B0            = 3'd0,
        REG_FEEDBACK_A1        = 3'd1,
        REG_FEEDBACK_A2        = 3'd2,
        REG_PRESET_GAIN_FIRST  = 3'd3,
        REG_PRESET_GAIN_SECOND = 3'd4
    } bbl_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_F_A1L,
        ST_F_A1H,
        ST_F_A2L,
        ST_F_A2H,
        ST_F_A2D,
        ST_F_W,
        ST_F_SAT,
        ST_F_SUM,
        ST_F_B0L,
        ST_F_B0H,
        ST_F_B0D,
        ST_F_OUT,
        ST_P_G1,
        ST_P_G2,
        ST_P_ST
    } bbl_state_t;

endpackage

>>> hw/rtl/bbl_in_if.sv
// ----------------------------------------------------------------------------
// Biquad low-pass input channel
// Valid/ready channel carrying a command and one sample.
// ----------------------------------------------------------------------------
interface bbl_in_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic signed [bbl_pkg::SAMPLE_W-1:0] sample_in;

    modport source (output valid, output cmd, output sample_in, input ready);
    modport sink   (input valid, input cmd, input sample_in, output ready);
endinterface

>>> hw/rtl/bbl_out_if.sv
// ----------------------------------------------------------------------------
// Biquad low-pass output channel
// Valid/ready channel carrying one filtered sample and its clip flag.
// ----------------------------------------------------------------------------
interface bbl_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [bbl_pkg::SAMPLE_W-1:0] filtered;
    logic                                clipped;

    modport source (output valid, output filtered, output clipped, input ready);
    modport sink   (input valid, input filtered, input clipped, output ready);
endinterface

>>> hw/rtl/butterworth_biquad_lowpass_unit.sv
// ----------------------------------------------------------------------------
// Butterworth biquad low-pass unit
// Second-order direct form II low-pass, numerator 1,2,1, on one shared
// 32x26 multiplier under a sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : sink, one transfer per command. cmd 0 filters sample_in, cmd 1
//            presets both delays from sample_in and the preset gains.
//   out_ch : source, one transfer per filter command (filtered, clipped).
//   cfg    : cfg_wr_en / cfg_index / cfg_data write port; write while idle.
// Sequence:
//   A filter command runs after its transfer on the shared multiplier
//   (six products, each followed by an accumulate); its result is
//   registered at the last step, and no new command is taken before
//   the sequencer is back in idle. A preset command emits nothing.
//   in_ch.ready is high only while the sequencer is idle.
// Reset:
//   rst_n clears the sequencer, output valid, coefficients and delays.
// Stall:
//   The result sits in an output register; the next command is accepted
//   meanwhile, and the sequencer holds at its last step until that
//   register is free.
// ----------------------------------------------------------------------------
`include "butterworth_biquad_lowpass_unit_defines.svh"

module butterworth_biquad_lowpass_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    bbl_in_if.sink                            in_ch,
    bbl_out_if.source                         out_ch,
    input  logic                              cfg_wr_en,
    input  logic [bbl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bbl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PROD_W = 58;
    localparam int ACC_W  = 68;
    localparam int W_W    = 53;
    localparam int SUM_W  = 50;

    bbl_pkg::bbl_state_t state_reg, state_next;

    logic signed [bbl_pkg::COEF_W-1:0]   gain_b0_reg, gain_b0_next;
    logic signed [bbl_pkg::COEF_W-1:0]   a1_reg, a1_next;
    logic signed [bbl_pkg::COEF_W-1:0]   a2_reg, a2_next;
    logic signed [bbl_pkg::PGAIN_W-1:0]  pg1_reg, pg1_next;
    logic signed [bbl_pkg::PGAIN_W-1:0]  pg2_reg, pg2_next;

    logic signed [bbl_pkg::STATE_W-1:0]  delay_first_reg, delay_first_next;
    logic signed [bbl_pkg::STATE_W-1:0]  delay_second_reg, delay_second_next;
    logic signed [bbl_pkg::STATE_W-1:0]  dnew_reg, dnew_next;
    logic signed [bbl_pkg::SAMPLE_W-1:0] x_reg, x_next;
    logic signed [PROD_W-1:0]            prod_reg, prod_next;
    logic signed [ACC_W-1:0]             acc_reg, acc_next;
    logic signed [W_W-1:0]               w_reg, w_next;
    logic signed [SUM_W-1:0]             sum_reg, sum_next;
    logic                                clip_reg, clip_next;

    logic                                out_valid_reg, out_valid_next;
    logic signed [bbl_pkg::SAMPLE_W-1:0] filtered_reg, filtered_next;
    logic                                clipped_reg, clipped_next;

    logic signed [31:0]                  mul_a;
    logic signed [25:0]                  mul_b;
    logic signed [ACC_W-1:0]             prod_ext;
    logic signed [ACC_W-1:0]             prod_sh;
    logic signed [W_W-1:0]               acc_term;
    logic signed [W_W-1:0]               x_q16;
    logic                                w_ovf;
    logic signed [bbl_pkg::STATE_W-1:0]  w_sat;
    logic signed [SUM_W-1:0]             sum_calc;
    logic signed [W_W-1:0]               y_round;
    logic                                y_ovf;
    logic signed [bbl_pkg::SAMPLE_W-1:0] y_sat;
    logic                                in_fire;
    logic                                out_free;

    assign in_ch.ready     = (state_reg == bbl_pkg::ST_IDLE);
    assign in_fire         = in_ch.valid && in_ch.ready;
    assign out_free        = !out_valid_reg || out_ch.ready;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.filtered = filtered_reg;
    assign out_ch.clipped  = clipped_reg;

    // low partial product is placed as is, high one at bit 25; high
    // products stay within 43 signed bits
    assign prod_ext = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign prod_sh  = {prod_reg[42:0], 25'd0};
    assign acc_term = {acc_reg[ACC_W-1], acc_reg[ACC_W-1:16]};
    assign x_q16    = {{(W_W-32){x_reg[15]}}, x_reg, 16'd0};

    assign w_ovf = !((&w_reg[W_W-1:47]) || !(|w_reg[W_W-1:47]));
    assign w_sat = w_ovf ? (w_reg[W_W-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
                         : w_reg[47:0];

    assign sum_calc = {{2{dnew_reg[47]}}, dnew_reg}
                    + {delay_first_reg[47], delay_first_reg, 1'b0}
                    + {{2{delay_second_reg[47]}}, delay_second_reg};

    assign y_round = acc_term + 53'sd32768;
    assign y_ovf   = !((&y_round[W_W-1:31]) || !(|y_round[W_W-1:31]));
    assign y_sat   = y_ovf ? (y_round[W_W-1] ? 16'sh8000 : 16'sh7fff)
                           : y_round[31:16];

    assign prod_next = mul_a * mul_b;

    always_comb
    begin
        state_next        = state_reg;
        gain_b0_next      = gain_b0_reg;
        a1_next           = a1_reg;
        a2_next           = a2_reg;
        pg1_next          = pg1_reg;
        pg2_next          = pg2_reg;
        delay_first_next  = delay_first_reg;
        delay_second_next = delay_second_reg;
        dnew_next         = dnew_reg;
        x_next            = x_reg;
        acc_next          = acc_reg;
        w_next            = w_reg;
        sum_next          = sum_reg;
        clip_next         = clip_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        filtered_next     = filtered_reg;
        clipped_next      = clipped_reg;
        mul_a             = '0;
        mul_b             = '0;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                bbl_pkg::REG_GAIN_B0:            gain_b0_next = cfg_data[17:0];
                bbl_pkg::REG_FEEDBACK_A1:        a1_next      = cfg_data[17:0];
                bbl_pkg::REG_FEEDBACK_A2:        a2_next      = cfg_data[17:0];
                bbl_pkg::REG_PRESET_GAIN_FIRST:  pg1_next     = cfg_data;
                bbl_pkg::REG_PRESET_GAIN_SECOND: pg2_next     = cfg_data;
                default: ;
            endcase
        end

        unique case (state_reg)
            bbl_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    x_next     = in_ch.sample_in;
                    state_next = in_ch.cmd ? bbl_pkg::ST_P_G1 : bbl_pkg::ST_F_A1L;
                end
            end
            bbl_pkg::ST_F_A1L:
            begin
                mul_a      = {{14{a1_reg[17]}}, a1_reg};
                mul_b      = {1'b0, delay_first_reg[24:0]};
                state_next = bbl_pkg::ST_F_A1H;
            end
            bbl_pkg::ST_F_A1H:
            begin
                mul_a      = {{14{a1_reg[17]}}, a1_reg};
                mul_b      = {{3{delay_first_reg[47]}}, delay_first_reg[47:25]};
                acc_next   = prod_ext + 68'sd32768;
                state_next = bbl_pkg::ST_F_A2L;
            end
            bbl_pkg::ST_F_A2L:
            begin
                mul_a      = {{14{a2_reg[17]}}, a2_reg};
                mul_b      = {1'b0, delay_second_reg[24:0]};
                acc_next   = acc_reg + prod_sh;
                state_next = bbl_pkg::ST_F_A2H;
            end
            bbl_pkg::ST_F_A2H:
            begin
                mul_a      = {{14{a2_reg[17]}}, a2_reg};
                mul_b      = {{3{delay_second_reg[47]}}, delay_second_reg[47:25]};
                w_next     = x_q16 + acc_term;
                acc_next   = prod_ext + 68'sd32768;
                state_next = bbl_pkg::ST_F_A2D;
            end
            bbl_pkg::ST_F_A2D:
            begin
                acc_next   = acc_reg + prod_sh;
                state_next = bbl_pkg::ST_F_W;
            end
            bbl_pkg::ST_F_W:
            begin
                w_next     = w_reg + acc_term;
                state_next = bbl_pkg::ST_F_SAT;
            end
            bbl_pkg::ST_F_SAT:
            begin
                dnew_next  = w_sat;
                clip_next  = w_ovf;
                state_next = bbl_pkg::ST_F_SUM;
            end
            bbl_pkg::ST_F_SUM:
            begin
                sum_next   = sum_calc;
                state_next = bbl_pkg::ST_F_B0L;
            end
            bbl_pkg::ST_F_B0L:
            begin
                mul_a      = {{14{gain_b0_reg[17]}}, gain_b0_reg};
                mul_b      = {1'b0, sum_reg[24:0]};
                state_next = bbl_pkg::ST_F_B0H;
            end
            bbl_pkg::ST_F_B0H:
            begin
                mul_a      = {{14{gain_b0_reg[17]}}, gain_b0_reg};
                mul_b      = {sum_reg[SUM_W-1], sum_reg[SUM_W-1:25]};
                acc_next   = prod_ext + 68'sd32768;
                state_next = bbl_pkg::ST_F_B0D;
            end
            bbl_pkg::ST_F_B0D:
            begin
                acc_next   = acc_reg + prod_sh;
                state_next = bbl_pkg::ST_F_OUT;
            end
            bbl_pkg::ST_F_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    filtered_next     = y_sat;
                    clipped_next      = clip_reg || y_ovf;
                    delay_second_next = delay_first_reg;
                    delay_first_next  = dnew_reg;
                    state_next        = bbl_pkg::ST_IDLE;
                end
            end
            bbl_pkg::ST_P_G1:
            begin
                mul_a      = pg1_reg;
                mul_b      = {{10{x_reg[15]}}, x_reg};
                state_next = bbl_pkg::ST_P_G2;
            end
            bbl_pkg::ST_P_G2:
            begin
                mul_a            = pg2_reg;
                mul_b            = {{10{x_reg[15]}}, x_reg};
                delay_first_next = prod_reg[47:0];
                state_next       = bbl_pkg::ST_P_ST;
            end
            bbl_pkg::ST_P_ST:
            begin
                delay_second_next = prod_reg[47:0];
                state_next        = bbl_pkg::ST_IDLE;
            end
            default: state_next = bbl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bbl_pkg::ST_IDLE;
            out_valid_reg    <= 1'b0;
            gain_b0_reg      <= '0;
            a1_reg           <= '0;
            a2_reg           <= '0;
            pg1_reg          <= '0;
            pg2_reg          <= '0;
            delay_first_reg  <= '0;
            delay_second_reg <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            out_valid_reg    <= out_valid_next;
            gain_b0_reg      <= gain_b0_next;
            a1_reg           <= a1_next;
            a2_reg           <= a2_next;
            pg1_reg          <= pg1_next;
            pg2_reg          <= pg2_next;
            delay_first_reg  <= delay_first_next;
            delay_second_reg <= delay_second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dnew_reg     <= dnew_next;
        x_reg        <= x_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        w_reg        <= w_next;
        sum_reg      <= sum_next;
        clip_reg     <= clip_next;
        filtered_reg <= filtered_next;
        clipped_reg  <= clipped_next;
    end

    `BBL_ASSERT(a_out_from_last_step, $rose(out_valid_reg) |-> $past(state_reg) == bbl_pkg::ST_F_OUT)
    `BBL_ASSERT(a_accept_starts_seq, in_fire |=> (state_reg == bbl_pkg::ST_F_A1L || state_reg == bbl_pkg::ST_P_G1))
    `BBL_ASSERT(a_preset_silent, (in_fire && in_ch.cmd) |=> !$rose(out_valid_reg))
    `BBL_ASSERT(a_delay_shift, (state_reg == bbl_pkg::ST_F_OUT && out_free) |=> delay_second_reg == $past(delay_first_reg))

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Biquad low-pass unit testbench
// Drives filter and preset commands through the valid/ready input channel
// and checks each filtered sample and clip flag against a fixed-point
// predictor. Coefficient sets are switched while the unit is idle: reset
// zeros, Butterworth designs, full-scale extremes and random sets. Sender
// gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD     = 6;
    localparam int SETTLE_CYCLES   = 20;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int MAX_GAP         = 40;
    localparam int MAX_REPORTS     = 10;

    localparam longint STATE_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint STATE_MIN = -STATE_MAX - 1;
    localparam longint OUT_MAX   = 32767;
    localparam longint OUT_MIN   = -32768;
    localparam longint HALF_LSB  = 32768;

    typedef enum logic {
        CMD_FILTER = 1'b0,
        CMD_PRESET = 1'b1
    } biquad_cmd_t;

    typedef enum int {
        SET_BW_LOW,
        SET_BW_MID,
        SET_EXT_MAX,
        SET_EXT_MIN,
        SET_EXT_MIX,
        SET_RAND_FULL,
        SET_RAND_MILD,
        SET_ZERO
    } coef_set_t;

    typedef struct packed {
        logic signed [bbl_pkg::SAMPLE_W-1:0] filtered;
        logic                                clipped;
    } biquad_result_t;

    class biquad_scoreboard;
        longint         b0;
        longint         a1;
        longint         a2;
        longint         pgain1;
        longint         pgain2;
        longint         delay1;
        longint         delay2;
        biquad_result_t expected_q[$];
        int             errors;
        int             n_filter;
        int             n_preset;
        int             n_results;
        int             n_clipped;

        // coefficient times Q.16 value, rounded half up to Q.16
        function longint round_mul(longint c, longint s);
            longint hi;
            longint lo;
            hi = s >>> 16;
            lo = s - (hi <<< 16);
            return c * hi + ((c * lo + HALF_LSB) >>> 16);
        endfunction

        function void write_reg(bbl_pkg::bbl_reg_t idx,
                                logic [bbl_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                bbl_pkg::REG_GAIN_B0:
                    b0 = longint'($signed(data[bbl_pkg::COEF_W-1:0]));
                bbl_pkg::REG_FEEDBACK_A1:
                    a1 = longint'($signed(data[bbl_pkg::COEF_W-1:0]));
                bbl_pkg::REG_FEEDBACK_A2:
                    a2 = longint'($signed(data[bbl_pkg::COEF_W-1:0]));
                bbl_pkg::REG_PRESET_GAIN_FIRST:
                    pgain1 = longint'($signed(data[bbl_pkg::PGAIN_W-1:0]));
                bbl_pkg::REG_PRESET_GAIN_SECOND:
                    pgain2 = longint'($signed(data[bbl_pkg::PGAIN_W-1:0]));
                default: ;
            endcase
        endfunction

        function void note_input(biquad_cmd_t cmd,
                                 logic signed [bbl_pkg::SAMPLE_W-1:0] x);
            longint         xs;
            longint         w;
            longint         total;
            longint         y;
            logic           clip;
            biquad_result_t res;
            xs = longint'(x);
            if (cmd == CMD_PRESET)
            begin
                n_preset++;
                delay1 = pgain1 * xs;
                delay2 = pgain2 * xs;
                return;
            end
            n_filter++;
            clip = 1'b0;
            w = (xs <<< 16) + round_mul(a1, delay1) + round_mul(a2, delay2);
            if (w > STATE_MAX)
            begin
                w = STATE_MAX;
                clip = 1'b1;
            end
            else if (w < STATE_MIN)
            begin
                w = STATE_MIN;
                clip = 1'b1;
            end
            total = w + 2 * delay1 + delay2;
            y = (round_mul(b0, total) + HALF_LSB) >>> 16;
            if (y > OUT_MAX)
            begin
                y = OUT_MAX;
                clip = 1'b1;
            end
            else if (y < OUT_MIN)
            begin
                y = OUT_MIN;
                clip = 1'b1;
            end
            delay2 = delay1;
            delay1 = w;
            res.filtered = y[bbl_pkg::SAMPLE_W-1:0];
            res.clipped = clip;
            expected_q.push_back(res);
        endfunction

        function void check_result(logic signed [bbl_pkg::SAMPLE_W-1:0] filtered,
                                   logic clipped);
            biquad_result_t want;
            n_results++;
            if (clipped)
                n_clipped++;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("unexpected output transfer: filtered %0d clipped %0b",
                             filtered, clipped);
                return;
            end
            want = expected_q.pop_front();
            if (filtered !== want.filtered || clipped !== want.clipped)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result %0d: filtered %0d clipped %0b, expected %0d %0b",
                             n_results, filtered, clipped, want.filtered, want.clipped);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0)
            begin
                errors += expected_q.size();
                $display("%0d expected results never arrived", expected_q.size());
            end
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                src_valid = 1'b0;
    logic                                src_cmd = CMD_FILTER;
    logic signed [bbl_pkg::SAMPLE_W-1:0] src_sample = '0;
    logic                                sink_ready = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [bbl_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [bbl_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int sets_applied = 0;

    biquad_scoreboard results_sb;

    coef_set_t phase_plan [NUM_PHASES] = '{
        SET_BW_LOW, SET_EXT_MAX, SET_BW_MID, SET_RAND_FULL,
        SET_EXT_MIN, SET_RAND_MILD, SET_EXT_MIX, SET_ZERO,
        SET_RAND_MILD, SET_BW_LOW, SET_RAND_FULL, SET_BW_MID
    };

    bbl_in_if  in_ch ();
    bbl_out_if out_ch ();

    assign in_ch.valid     = src_valid;
    assign in_ch.cmd       = src_cmd;
    assign in_ch.sample_in = src_sample;
    assign out_ch.ready    = sink_ready;

    butterworth_biquad_lowpass_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(HALF_PERIOD) clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            sink_ready <= 1'b0;
        else
            sink_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
                results_sb.note_input(biquad_cmd_t'(in_ch.cmd), in_ch.sample_in);
            if (out_ch.valid && out_ch.ready)
                results_sb.check_result(out_ch.filtered, out_ch.clipped);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic signed [bbl_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return bbl_pkg::SAMPLE_W'($urandom_range(0, 255) - 128);
            default: return bbl_pkg::SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_item(biquad_cmd_t cmd, logic signed [bbl_pkg::SAMPLE_W-1:0] x);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            src_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        src_valid <= 1'b1;
        src_cmd <= cmd;
        src_sample <= x;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // waits on the clock first so the last accepted transfer is already noted
    task automatic drain_results();
        src_valid <= 1'b0;
        @(posedge clk);
        while (results_sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves the write enable high; the caller lowers it after the last write
    task automatic write_cfg(bbl_pkg::bbl_reg_t idx, logic [bbl_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        results_sb.write_reg(idx, data);
    endtask

    task automatic apply_setting(coef_set_t kind);
        logic [bbl_pkg::CFG_DATA_W-1:0] b0;
        logic [bbl_pkg::CFG_DATA_W-1:0] a1;
        logic [bbl_pkg::CFG_DATA_W-1:0] a2;
        logic [bbl_pkg::CFG_DATA_W-1:0] pg1;
        logic [bbl_pkg::CFG_DATA_W-1:0] pg2;
        case (kind)
            SET_BW_LOW:
            begin
                b0 = 4421;
                a1 = 74906;
                a2 = -27053;
                pg1 = 242891;
                pg2 = 242891;
            end
            SET_BW_MID:
            begin
                b0 = 19195;
                a1 = 0;
                a2 = -11244;
                pg1 = 55938;
                pg2 = 55938;
            end
            SET_EXT_MAX:
            begin
                b0 = 131071;
                a1 = 131071;
                a2 = 131071;
                pg1 = 32'h7FFF_FFFF;
                pg2 = 32'h7FFF_FFFF;
            end
            SET_EXT_MIN:
            begin
                b0 = -131072;
                a1 = -131072;
                a2 = -131072;
                pg1 = 32'h8000_0000;
                pg2 = 32'h8000_0000;
            end
            SET_EXT_MIX:
            begin
                b0 = 131071;
                a1 = 131071;
                a2 = -131072;
                pg1 = 32'h7FFF_FFFF;
                pg2 = 32'h8000_0000;
            end
            SET_RAND_FULL:
            begin
                b0 = $urandom;
                a1 = $urandom;
                a2 = $urandom;
                pg1 = $urandom;
                pg2 = $urandom;
            end
            SET_RAND_MILD:
            begin
                b0 = $urandom_range(0, 16384) - 8192;
                a1 = $urandom_range(0, 131071) - 65536;
                a2 = -$urandom_range(0, 60000);
                pg1 = $urandom_range(0, 1 << 20) - (1 << 19);
                pg2 = $urandom_range(0, 1 << 20) - (1 << 19);
            end
            default:
            begin
                b0 = '0;
                a1 = '0;
                a2 = '0;
                pg1 = '0;
                pg2 = '0;
            end
        endcase
        drain_results();
        write_cfg(bbl_pkg::REG_GAIN_B0, b0);
        write_cfg(bbl_pkg::REG_FEEDBACK_A1, a1);
        write_cfg(bbl_pkg::REG_FEEDBACK_A2, a2);
        write_cfg(bbl_pkg::REG_PRESET_GAIN_FIRST, pg1);
        write_cfg(bbl_pkg::REG_PRESET_GAIN_SECOND, pg2);
        cfg_wr_en <= 1'b0;
        sets_applied++;
    endtask

    task automatic run_directed();
        // reset coefficients are zero: every output is zero
        send_item(CMD_FILTER, 16'sh7FFF);
        send_item(CMD_FILTER, 16'sh8000);
        send_item(CMD_PRESET, 16'sd1000);
        send_item(CMD_FILTER, 16'sd5);

        // preset then steady input, then full-scale steps
        apply_setting(SET_BW_LOW);
        send_item(CMD_PRESET, 16'sd10000);
        repeat (3) send_item(CMD_FILTER, 16'sd10000);
        send_item(CMD_FILTER, 16'sh7FFF);
        send_item(CMD_FILTER, 16'sh8000);
        send_item(CMD_FILTER, 16'sd0);

        // large presets push the new delay and the output into saturation
        apply_setting(SET_EXT_MAX);
        send_item(CMD_PRESET, 16'sh8000);
        send_item(CMD_FILTER, 16'sh8000);
        send_item(CMD_FILTER, 16'sh7FFF);
        send_item(CMD_PRESET, 16'sh7FFF);
        send_item(CMD_FILTER, 16'sh7FFF);
        send_item(CMD_FILTER, 16'sd0);

        apply_setting(SET_EXT_MIN);
        send_item(CMD_PRESET, 16'sh8000);
        send_item(CMD_FILTER, 16'sh7FFF);
        send_item(CMD_FILTER, 16'sh8000);
        send_item(CMD_FILTER, 16'sd1);

        apply_setting(SET_EXT_MIX);
        send_item(CMD_PRESET, 16'sh7FFF);
        send_item(CMD_FILTER, -16'sd1);
        send_item(CMD_FILTER, 16'sd0);
    endtask

    task automatic run_random(int count);
        int                                  sent;
        int                                  steady;
        int                                  r;
        bit                                  paused;
        logic signed [bbl_pkg::SAMPLE_W-1:0] x;
        sent = 0;
        paused = 1'b0;
        while (sent < count)
        begin
            if (!paused && sent >= count / 2)
            begin
                drain_results();
                paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 15)
            begin
                // steady run: preset followed by the same value
                x = pick_sample();
                steady = $urandom_range(2, 8);
                send_item(CMD_PRESET, x);
                repeat (steady) send_item(CMD_FILTER, x);
                sent += steady + 1;
            end
            else if (r < 25)
            begin
                send_item(CMD_PRESET, pick_sample());
                sent++;
            end
            else
            begin
                send_item(CMD_FILTER, pick_sample());
                sent++;
            end
        end
    endtask

    initial
    begin
        results_sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            apply_setting(phase_plan[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 68;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 68;
                end
                default:
                begin
                    send_idle_pct = 10;
                    recv_stall_pct = 10;
                end
            endcase
            run_random(ITEMS_PER_PHASE);
        end
        drain_results();
        results_sb.close_out();
        $display("Covered %0d filter and %0d preset transfers over %0d coefficient sets,",
                 results_sb.n_filter, results_sb.n_preset, sets_applied);
        $display("with %0d results checked (%0d clipped) and %0d mismatches.",
                 results_sb.n_results, results_sb.n_clipped, results_sb.errors);
        if (results_sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/bbl_pkg.sv
hw/rtl/bbl_in_if.sv
hw/rtl/bbl_out_if.sv
hw/rtl/butterworth_biquad_lowpass_unit.sv
sim/testbench.sv
